@@ hdl/xpsc_pkg.sv @@
package xpsc_pkg;

    localparam int BUF_DEPTH = 2048;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int SHARDS    = 64;
    localparam int IDX_W     = $clog2(SHARDS);
    localparam int CNT_W     = IDX_W + 1;

    localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(BUF_DEPTH);
    localparam logic [CNT_W-1:0] MAX_SHARDS = CNT_W'(SHARDS);

    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_BYTE  = 3'd1;
    localparam logic [2:0] REQ_EMPTY = 3'd2;
    localparam logic [2:0] REQ_FIN   = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_DATA  = 3'd1;
    localparam logic [2:0] ST_NO_RECOV = 3'd2;
    localparam logic [2:0] ST_BAD_IDX  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic KIND_FINISH = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic [2:0]        req_type;
        logic              recover_mode;
        logic [IDX_W-1:0]  missing_index;
        logic [7:0]        shard_byte;
        logic              shard_last;
        logic [ADDR_W-1:0] read_pos;
    } t_in_item;

    typedef struct packed {
        logic             kind;
        logic [2:0]       status;
        logic [LEN_W-1:0] result_length;
        logic [7:0]       result_byte;
    } t_out_item;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

endpackage

@@ hdl/xor_parity_shard_codec_core.sv @@
// A byte that extends the result is written straight to the buffer; a byte that folds
// into an existing entry, and a read below the result length, read the buffer RAM first
// and finish in a second state that stalls the input. Other transactions need no second
// state. A finish result, or a read result beyond the length, appears in the cycle after
// acceptance; a read result below the length passes the RAM read register, then the
// output register. Reset clears the frame counters, mode and output valid; the buffer is
// not cleared, as an entry is only read after the frame has written it.
module xor_parity_shard_codec_core import xpsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BYTE = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_longest, n_longest;
    logic [LEN_W-1:0]  r_byte_pos, n_byte_pos;
    logic [CNT_W-1:0]  r_shard_cnt, n_shard_cnt;
    logic [CNT_W-1:0]  r_empty_cnt, n_empty_cnt;
    logic              r_mode, n_mode;
    logic [IDX_W-1:0]  r_skip, n_skip;
    logic              r_ovf, n_ovf;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    logic [ADDR_W-1:0] r_rmw_addr, n_rmw_addr;
    logic [7:0]        r_rmw_val, n_rmw_val;

    t_ram_req          w_ram_req;
    logic [7:0]        w_rd_data;
    logic              w_in_acc;
    logic              w_gives_result;
    logic              w_skip_byte;
    logic [7:0]        w_byte_val;
    logic [CNT_W-1:0]  w_fin_cnt;
    logic [2:0]        w_fin_status;

    xpsc_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (w_ram_req),
        .o_rd_data (w_rd_data)
    );

    assign w_gives_result = (i_in_data.req_type == REQ_FIN) ||
                            (i_in_data.req_type == REQ_READ);
    assign o_in_stall = (r_state != S_IDLE) ||
                        (w_gives_result && r_out_valid && i_out_stall);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_skip_byte = r_mode && ({1'b0, r_skip} == r_shard_cnt);
    assign w_byte_val  = w_skip_byte ? 8'd0 : i_in_data.shard_byte;

    assign w_fin_cnt = ((r_byte_pos != '0) && (r_shard_cnt < MAX_SHARDS)) ?
                       r_shard_cnt + CNT_W'(1) : r_shard_cnt;

    always_comb begin
        if (r_ovf) begin
            w_fin_status = ST_OVERFLOW;
        end else if (!r_mode) begin
            w_fin_status = ((w_fin_cnt == '0) || (r_longest == '0)) ? ST_NO_DATA : ST_OK;
        end else if ((w_fin_cnt == '0) || (r_empty_cnt != CNT_W'(1))) begin
            w_fin_status = ST_NO_RECOV;
        end else if ({1'b0, r_skip} >= w_fin_cnt) begin
            w_fin_status = ST_BAD_IDX;
        end else begin
            w_fin_status = ST_OK;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_longest   = r_longest;
        n_byte_pos  = r_byte_pos;
        n_shard_cnt = r_shard_cnt;
        n_empty_cnt = r_empty_cnt;
        n_mode      = r_mode;
        n_skip      = r_skip;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_rmw_addr  = r_rmw_addr;
        n_rmw_val   = r_rmw_val;
        w_ram_req   = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_BYTE: begin
                w_ram_req.wr_en   = 1'b1;
                w_ram_req.wr_addr = r_rmw_addr;
                w_ram_req.wr_data = w_rd_data ^ r_rmw_val;
                n_state           = S_IDLE;
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_out       = '{kind: KIND_READ, status: ST_OK,
                                result_length: r_longest, result_byte: w_rd_data};
                n_state     = S_IDLE;
            end
            default: begin
            end
        endcase

        if (w_in_acc) begin
            unique case (i_in_data.req_type)
                REQ_START: begin
                    n_longest   = '0;
                    n_byte_pos  = '0;
                    n_shard_cnt = '0;
                    n_empty_cnt = '0;
                    n_ovf       = 1'b0;
                    n_mode      = i_in_data.recover_mode;
                    n_skip      = i_in_data.missing_index;
                end
                REQ_BYTE: begin
                    if (r_shard_cnt >= MAX_SHARDS) begin
                        n_ovf = 1'b1;
                    end else begin
                        if (r_byte_pos >= MAX_LEN) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_byte_pos = r_byte_pos + LEN_W'(1);
                            if (r_byte_pos >= r_longest) begin
                                w_ram_req.wr_en   = 1'b1;
                                w_ram_req.wr_addr = r_byte_pos[ADDR_W-1:0];
                                w_ram_req.wr_data = w_byte_val;
                                n_longest         = r_byte_pos + LEN_W'(1);
                            end else begin
                                w_ram_req.rd_en   = 1'b1;
                                w_ram_req.rd_addr = r_byte_pos[ADDR_W-1:0];
                                n_rmw_addr        = r_byte_pos[ADDR_W-1:0];
                                n_rmw_val         = w_byte_val;
                                n_state           = S_BYTE;
                            end
                        end
                        if (i_in_data.shard_last) begin
                            n_shard_cnt = r_shard_cnt + CNT_W'(1);
                            n_byte_pos  = '0;
                        end
                    end
                end
                REQ_EMPTY: begin
                    if (r_shard_cnt >= MAX_SHARDS) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_shard_cnt = r_shard_cnt + CNT_W'(1);
                        n_empty_cnt = r_empty_cnt + CNT_W'(1);
                    end
                    n_byte_pos = '0;
                end
                REQ_FIN: begin
                    n_shard_cnt = w_fin_cnt;
                    n_byte_pos  = '0;
                    n_out_valid = 1'b1;
                    n_out       = '{kind: KIND_FINISH, status: w_fin_status,
                                    result_length: (w_fin_status == ST_OK) ? r_longest : '0,
                                    result_byte: 8'd0};
                end
                REQ_READ: begin
                    if ({1'b0, i_in_data.read_pos} < r_longest) begin
                        w_ram_req.rd_en   = 1'b1;
                        w_ram_req.rd_addr = i_in_data.read_pos;
                        n_state           = S_READ;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = '{kind: KIND_READ, status: ST_OK,
                                        result_length: r_longest, result_byte: 8'd0};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_longest   <= '0;
            r_byte_pos  <= '0;
            r_shard_cnt <= '0;
            r_empty_cnt <= '0;
            r_mode      <= 1'b0;
            r_skip      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_longest   <= n_longest;
            r_byte_pos  <= n_byte_pos;
            r_shard_cnt <= n_shard_cnt;
            r_empty_cnt <= n_empty_cnt;
            r_mode      <= n_mode;
            r_skip      <= n_skip;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_rmw_addr <= n_rmw_addr;
        r_rmw_val  <= n_rmw_val;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/xpsc_ram.sv @@
module xpsc_ram import xpsc_pkg::*; (
    input  logic      i_clk,
    input  t_ram_req  i_req,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/xpsc_checker.sv @@
module xpsc_checker import xpsc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // A stalled result transaction must hold until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // A read result always carries an ok status.
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_READ) |-> o_out_data.status == ST_OK)
        else $error("read result with non-ok status");

    // A finish result carries no byte, and no length unless the status is ok.
    a_fin_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_FINISH) |->
        (o_out_data.result_byte == 8'd0) &&
        ((o_out_data.status == ST_OK) || (o_out_data.result_length == '0)))
        else $error("finish result fields inconsistent");

    // A start transaction produces no result.
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.req_type == REQ_START)
        |=> !$rose(o_out_valid))
        else $error("result appeared after a start transaction");

endmodule

bind xor_parity_shard_codec_core xpsc_checker u_xpsc_checker (.*);

@@ tb/sv/xor_parity_shard_codec_core_tb.sv @@
`timescale 1ns / 100ps

module xor_parity_shard_codec_core_tb;
    import xpsc_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int gap_pct    = 0;
    int stall_pct  = 0;
    int noise_pct  = 0;
    int stall_left = 0;

    int items_sent   = 0;
    int frames       = 0;
    int results_seen = 0;
    int errors       = 0;

    logic [7:0]       parity_buf [BUF_DEPTH];
    logic [LEN_W-1:0] frame_len    = '0;
    logic [LEN_W-1:0] shard_pos    = '0;
    logic [CNT_W-1:0] shards_seen  = '0;
    logic [CNT_W-1:0] empties_seen = '0;
    logic             recover_on   = 1'b0;
    logic [IDX_W-1:0] skip_shard   = '0;
    logic             overflowed   = 1'b0;

    t_out_item owed_codec_outputs [$];

    xor_parity_shard_codec_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Folds one accepted transaction into the XOR buffer and queues any result it owes.
    task automatic apply_xor_codec(input t_in_item it);
        t_out_item  res;
        logic [7:0] v;
        logic [2:0] st;
        res = '0;
        case (it.req_type)
            REQ_START: begin
                frame_len    = '0;
                shard_pos    = '0;
                shards_seen  = '0;
                empties_seen = '0;
                overflowed   = 1'b0;
                recover_on   = it.recover_mode;
                skip_shard   = it.missing_index;
            end
            REQ_BYTE: begin
                if (shards_seen >= MAX_SHARDS) begin
                    overflowed = 1'b1;
                end else begin
                    if (shard_pos >= MAX_LEN) begin
                        overflowed = 1'b1;
                    end else begin
                        v = (recover_on && shards_seen == CNT_W'(skip_shard)) ? 8'h00
                                                                               : it.shard_byte;
                        if (shard_pos >= frame_len) begin
                            parity_buf[shard_pos[ADDR_W-1:0]] = v;
                            frame_len = shard_pos + LEN_W'(1);
                        end else begin
                            parity_buf[shard_pos[ADDR_W-1:0]] ^= v;
                        end
                        shard_pos++;
                    end
                    if (it.shard_last) begin
                        if (shards_seen < MAX_SHARDS) shards_seen++;
                        shard_pos = '0;
                    end
                end
            end
            REQ_EMPTY: begin
                if (shards_seen >= MAX_SHARDS) begin
                    overflowed = 1'b1;
                end else begin
                    shards_seen++;
                    empties_seen++;
                end
                shard_pos = '0;
            end
            REQ_FIN: begin
                if (shard_pos != 0) begin
                    if (shards_seen < MAX_SHARDS) shards_seen++;
                    shard_pos = '0;
                end
                if (overflowed) begin
                    st = ST_OVERFLOW;
                end else if (!recover_on) begin
                    st = (shards_seen == 0 || frame_len == 0) ? ST_NO_DATA : ST_OK;
                end else if (shards_seen == 0 || empties_seen != 1) begin
                    st = ST_NO_RECOV;
                end else if (CNT_W'(skip_shard) >= shards_seen) begin
                    st = ST_BAD_IDX;
                end else begin
                    st = ST_OK;
                end
                res.kind          = KIND_FINISH;
                res.status        = st;
                res.result_length = (st == ST_OK) ? frame_len : '0;
                owed_codec_outputs.push_back(res);
            end
            REQ_READ: begin
                res.kind          = KIND_READ;
                res.status        = ST_OK;
                res.result_length = frame_len;
                res.result_byte   = (LEN_W'(it.read_pos) < frame_len) ? parity_buf[it.read_pos]
                                                                       : 8'h00;
                owed_codec_outputs.push_back(res);
            end
            default: ;
        endcase
    endtask

    function automatic t_in_item make_item(input logic [2:0] req);
        t_in_item    it;
        logic [31:0] r;
        r  = $urandom;
        it = r[$bits(t_in_item)-1:0];
        it.req_type = req;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        apply_xor_codec(it);
        if (it.req_type <= REQ_READ) items_sent++;
    endtask

    task automatic send_req(input logic [2:0] req);
        send_item(make_item(req));
    endtask

    task automatic send_start(input logic mode, input int miss);
        t_in_item it;
        it = make_item(REQ_START);
        it.recover_mode  = mode;
        it.missing_index = IDX_W'(miss);
        frames++;
        send_item(it);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item it;
        it = make_item(REQ_BYTE);
        it.shard_byte = b;
        it.shard_last = last;
        send_item(it);
    endtask

    task automatic send_read(input int pos);
        t_in_item it;
        it = make_item(REQ_READ);
        it.read_pos = ADDR_W'(pos);
        send_item(it);
    endtask

    task automatic maybe_noise;
        if (noise_pct != 0 && $urandom_range(99) < noise_pct)
            send_req(3'($urandom_range(7)));
    endtask

    task automatic send_shard(input int len, input bit mark);
        for (int i = 0; i < len; i++) begin
            maybe_noise();
            send_byte(8'($urandom_range(255)), mark && i == len - 1);
        end
    endtask

    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            stall_left <= $urandom_range(12);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : check_outputs
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (owed_codec_outputs.size() == 0) begin
                report_mismatch("result with no transaction awaiting it", 32'(out_data), 0);
            end else begin
                want = owed_codec_outputs.pop_front();
                if (out_data.kind != want.kind)
                    report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
                if (out_data.status != want.status)
                    report_mismatch("status", 32'(out_data.status), 32'(want.status));
                if (out_data.result_length != want.result_length)
                    report_mismatch("result_length", 32'(out_data.result_length),
                                    32'(want.result_length));
                if (out_data.result_byte != want.result_byte)
                    report_mismatch("result_byte", 32'(out_data.result_byte),
                                    32'(want.result_byte));
            end
        end
    end

    task automatic test_before_any_frame;
        send_read(0);
        send_read(BUF_DEPTH - 1);
        send_req(REQ_FIN);
        for (int r = REQ_READ + 1; r < 8; r++) send_req(3'(r));
    endtask

    task automatic test_parity_frame;
        send_start(1'b0, 0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'h0F, 1'b1);
        send_req(REQ_EMPTY);
        send_req(REQ_FIN);
        send_read(0);
        send_read(2);
        send_read(3);
    endtask

    task automatic test_recovery_frames;
        send_start(1'b1, 1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        send_req(REQ_EMPTY);
        send_byte(8'h56, 1'b1);
        send_req(REQ_FIN);
        send_read(0);
        send_start(1'b1, 0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b1);
        send_req(REQ_EMPTY);
        send_byte(8'h11, 1'b1);
        send_req(REQ_FIN);
        send_read(1);
        send_start(1'b1, 63);
        send_req(REQ_EMPTY);
        send_req(REQ_FIN);
        send_start(1'b1, 0);
        send_byte(8'h80, 1'b1);
        send_req(REQ_FIN);
        send_start(1'b0, 0);
        send_req(REQ_EMPTY);
        send_req(REQ_FIN);
    endtask

    task automatic test_broken_shards;
        send_start(1'b0, 0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_req(REQ_EMPTY);
        send_byte(8'h04, 1'b0);
        send_req(REQ_FIN);
        send_read(0);
        send_read(1);
    endtask

    task automatic test_size_limits;
        gap_pct   = 5;
        stall_pct = 5;
        send_start(1'b1, 1);
        send_shard(BUF_DEPTH + 1, 1'b1);
        send_req(REQ_FIN);
        send_read(BUF_DEPTH - 1);
        send_start(1'b0, 0);
        repeat (SHARDS) send_req(REQ_EMPTY);
        send_req(REQ_EMPTY);
        send_byte(8'hC3, 1'b1);
        send_req(REQ_FIN);
        send_start(1'b1, SHARDS - 1);
        repeat (SHARDS - 1) send_byte(8'($urandom_range(255)), 1'b1);
        send_req(REQ_EMPTY);
        send_req(REQ_FIN);
        send_read(0);
    endtask

    task automatic test_random_frames(input int target);
        int first;
        int nsh;
        int miss;
        int prof;
        bit recov;
        bit empty;
        first     = items_sent;
        noise_pct = 2;
        while (items_sent - first < target) begin
            if (target - (items_sent - first) < 100) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                prof      = $urandom_range(2);
                gap_pct   = prof * 20;
                stall_pct = $urandom_range(2) * 20;
            end
            recov = 1'($urandom_range(1));
            nsh   = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            miss  = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(nsh - 1);
            send_start(recov, miss);
            for (int s = 0; s < nsh; s++) begin
                maybe_noise();
                empty = (recov && s == miss) ? ($urandom_range(4) != 0)
                                             : ($urandom_range(14) == 0);
                if (empty)
                    send_req(REQ_EMPTY);
                else
                    send_shard(($urandom_range(19) == 0) ? $urandom_range(25, 300)
                                                         : $urandom_range(1, 24),
                               $urandom_range(19) != 0);
            end
            if ($urandom_range(19) != 0) begin
                send_req(REQ_FIN);
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(4) == 0)
                        send_read($urandom_range(BUF_DEPTH - 1));
                    else
                        send_read($urandom_range(int'(frame_len) + 3));
                end
            end
        end
        noise_pct = 0;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_before_any_frame();
        test_parity_frame();
        test_recovery_frames();
        test_broken_shards();
        test_size_limits();
        test_random_frames(300);
        in_valid <= 1'b0;
        while (owed_codec_outputs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        $display("Sent %0d transactions over %0d frames of parity and recovery work,",
                 items_sent, frames);
        $display("including full-length and overflowing shards; %0d results compared.",
                 results_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/xpsc_pkg.sv
hdl/xpsc_ram.sv
hdl/xor_parity_shard_codec_core.sv
hdl/xpsc_checker.sv
tb/sv/xor_parity_shard_codec_core_tb.sv
